// ===== rtl/core/nearest_palette_pixel_quantizer_unit_macros.svh =====
// Assertion macros for the palette quantizer checker.
// Expects signals named clock and reset in the scope of use.
`ifndef NEAREST_PALETTE_PIXEL_QUANTIZER_UNIT_MACROS_SVH
`define NEAREST_PALETTE_PIXEL_QUANTIZER_UNIT_MACROS_SVH

// checked at every edge, reset included
`define NPQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

// checked only outside reset
`define NPQ_ASSERT_LIVE(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

`endif

// ===== rtl/core/npq_pkg.sv =====
// Shared types, sizes and palette for the palette quantizer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package npq_pkg;

   // image and field sizes
   localparam int MAX_SIDE    = 4096;
   localparam int COORD_W     = $clog2(MAX_SIDE);
   localparam int SIDE_W      = 13;
   localparam int OFFSET_W    = 12;
   localparam int BOARD_W     = 13;
   localparam int CHAN_W      = 8;
   localparam int COLOR_W     = 5;

   // palette search
   localparam int PALETTE_SIZE = 32;
   localparam int PAL_ENTRIES  = 32;
   localparam int TREE_LEVELS  = $clog2(PAL_ENTRIES);
   localparam int TREE_LEAVES  = 1 << TREE_LEVELS;
   localparam int TREE_NODES   = 2 * TREE_LEAVES - 1;
   localparam int LEAF_IDX_W   = TREE_LEVELS;
   localparam int SQ_W         = 2 * CHAN_W;
   localparam int DIST_W       = SQ_W + 2;
   localparam int PIPE_STAGES  = TREE_LEVELS + 2;

   // queues
   localparam int MIDQ_PTR_W  = 2;
   localparam int MIDQ_DEPTH  = 1 << MIDQ_PTR_W;
   localparam int OUTQ_PTR_W  = 4;
   localparam int OUTQ_DEPTH  = 1 << OUTQ_PTR_W;

   // register port
   localparam int REG_INDEX_W = 2;
   localparam int CSR_ADDR_W  = REG_INDEX_W + 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [SIDE_W-1:0] WIDTH_RESET  = SIDE_W'(640);
   localparam logic [SIDE_W-1:0] HEIGHT_RESET = SIDE_W'(480);

   typedef enum logic [REG_INDEX_W-1:0] {
      REG_IMAGE_WIDTH,
      REG_IMAGE_HEIGHT,
      REG_OFFSET_X,
      REG_OFFSET_Y
   } csr_reg_type;

   // fixed palette, {red, green, blue}
   localparam logic [3*CHAN_W-1:0] PALETTE_RGB [PALETTE_SIZE] = '{
      24'h000000, 24'hFFFFFF, 24'hAAAAAA, 24'h555555,
      24'hFED3C7, 24'hFFC4CE, 24'hFAAC8E, 24'hFF8B83,
      24'hF44336, 24'hE91E63, 24'hE2669E, 24'h9C27B0,
      24'h673AB7, 24'h3F51B5, 24'h004670, 24'h057197,
      24'h2196F3, 24'h00BCD4, 24'h3BE5DB, 24'h97FDDC,
      24'h167300, 24'h37A93C, 24'h89E642, 24'hD7FF07,
      24'hFFF6D1, 24'hF8CB8C, 24'hFFEB3B, 24'hFFC107,
      24'hFF9800, 24'hFF5722, 24'hB83F27, 24'h795548
   };

   // effective sizes minus one, offsets
   typedef struct packed {
      logic [COORD_W-1:0]  w_m1;
      logic [COORD_W-1:0]  h_m1;
      logic [OFFSET_W-1:0] offset_x;
      logic [OFFSET_W-1:0] offset_y;
   } cfg_type;

   typedef struct packed {
      logic [BOARD_W-1:0] board_x;
      logic [BOARD_W-1:0] board_y;
      logic               image_done;
   } coord_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      coord_type         coord;
   } pix_item_type;

   typedef struct packed {
      logic [BOARD_W-1:0] board_x;
      logic [BOARD_W-1:0] board_y;
      logic [COLOR_W-1:0] color_index;
      logic               image_done;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== rtl/core/npq_csr.sv =====
// Configuration registers behind the APB-style port.
// Depends on npq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module npq_csr
   import npq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg,
   output logic                  size_wr
);

   logic [SIDE_W-1:0]   width_ff,  width_in;
   logic [SIDE_W-1:0]   height_ff, height_in;
   logic [OFFSET_W-1:0] offx_ff,   offx_in;
   logic [OFFSET_W-1:0] offy_ff,   offy_in;
   logic                wr_en;
   csr_reg_type         reg_sel;

   // size saturated to 1..MAX_SIDE, minus one
   function automatic logic [COORD_W-1:0] side_m1(input logic [SIDE_W-1:0] v);
      if (v == '0) begin
         return '0;
      end else if (v > SIDE_W'(MAX_SIDE)) begin
         return COORD_W'(MAX_SIDE - 1);
      end else begin
         return COORD_W'(v - SIDE_W'(1));
      end
   endfunction

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_sel = csr_reg_type'(paddr[CSR_ADDR_W-1:2]);
   assign size_wr = wr_en && (reg_sel == REG_IMAGE_WIDTH || reg_sel == REG_IMAGE_HEIGHT);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      offx_in   = offx_ff;
      offy_in   = offy_ff;
      prdata    = '0;
      unique case (reg_sel)
         REG_IMAGE_WIDTH: begin
            prdata = CSR_DATA_W'(width_ff);
            if (wr_en) width_in = pwdata[SIDE_W-1:0];
         end
         REG_IMAGE_HEIGHT: begin
            prdata = CSR_DATA_W'(height_ff);
            if (wr_en) height_in = pwdata[SIDE_W-1:0];
         end
         REG_OFFSET_X: begin
            prdata = CSR_DATA_W'(offx_ff);
            if (wr_en) offx_in = pwdata[OFFSET_W-1:0];
         end
         REG_OFFSET_Y: begin
            prdata = CSR_DATA_W'(offy_ff);
            if (wr_en) offy_in = pwdata[OFFSET_W-1:0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         offx_ff   <= '0;
         offy_ff   <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         offx_ff   <= offx_in;
         offy_ff   <= offy_in;
      end
   end

   assign cfg.w_m1     = side_m1(width_ff);
   assign cfg.h_m1     = side_m1(height_ff);
   assign cfg.offset_x = offx_ff;
   assign cfg.offset_y = offy_ff;

endmodule

`default_nettype wire

// ===== rtl/core/npq_front.sv =====
// Front end: pixel intake, column/row counters, board coordinates and
// the short queue toward the search pipeline. Depends on npq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module npq_front
   import npq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              size_wr,
   input  logic              push,
   output logic              full,
   input  logic [CHAN_W-1:0] red,
   input  logic [CHAN_W-1:0] green,
   input  logic [CHAN_W-1:0] blue,
   output logic              item_valid,
   output pix_item_type      item,
   input  logic              item_take
);

   logic [COORD_W-1:0]    col_ff, col_in, row_ff, row_in;
   logic [COORD_W-1:0]    col_cur, row_cur;
   logic                  last_col, last_row, accept;
   pix_item_type          item_in;
   pix_item_type          midq_ff [MIDQ_DEPTH];
   logic [MIDQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [MIDQ_PTR_W:0]   count_ff, count_in;

   assign full       = (count_ff == (MIDQ_PTR_W + 1)'(MIDQ_DEPTH));
   assign accept     = push && !full;
   assign item_valid = (count_ff != '0);
   assign item       = midq_ff[rd_ptr_ff];

   always_comb begin
      // pull a stray counter back into the image
      col_cur  = (col_ff > cfg.w_m1) ? '0 : col_ff;
      row_cur  = (row_ff > cfg.h_m1) ? '0 : row_ff;
      last_col = (col_cur == cfg.w_m1);
      last_row = (row_cur == cfg.h_m1);

      item_in.red   = red;
      item_in.green = green;
      item_in.blue  = blue;
      item_in.coord.board_x    = BOARD_W'(col_cur) + BOARD_W'(cfg.offset_x);
      item_in.coord.board_y    = BOARD_W'(cfg.h_m1 - row_cur) + BOARD_W'(cfg.offset_y);
      item_in.coord.image_done = last_col && last_row;

      col_in = col_ff;
      row_in = row_ff;
      priority if (size_wr) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_cur + COORD_W'(1);
         end else begin
            col_in = col_cur + COORD_W'(1);
            row_in = row_cur;
         end
      end

      wr_ptr_in = wr_ptr_ff + MIDQ_PTR_W'(accept);
      rd_ptr_in = rd_ptr_ff + MIDQ_PTR_W'(item_take);
      count_in  = count_ff + (MIDQ_PTR_W + 1)'(accept) - (MIDQ_PTR_W + 1)'(item_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         midq_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/npq_search.sv =====
// Back end: nearest palette color search. One squared-difference stage,
// one distance stage, then a registered minimum tree. Depends on npq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module npq_search
   import npq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         issue,
   input  pix_item_type pix,
   output logic         res_valid,
   output rsp_item_type res
);

   logic [CHAN_W-1:0]     pix_chan [3];
   logic [CHAN_W-1:0]     pal_chan;
   logic [CHAN_W-1:0]     diff;
   logic [SQ_W-1:0]       sq_in [TREE_LEAVES][3];
   logic [SQ_W-1:0]       sq_ff [TREE_LEAVES][3];
   logic [DIST_W-1:0]     node_dist_in [TREE_NODES];
   logic [DIST_W-1:0]     node_dist_ff [TREE_NODES];
   logic [LEAF_IDX_W-1:0] node_idx_in [TREE_NODES];
   logic [LEAF_IDX_W-1:0] node_idx_ff [TREE_NODES];
   logic [PIPE_STAGES-1:0] valid_ff, valid_in;
   coord_type             side_ff [PIPE_STAGES];

   // squared channel differences, one lane per palette entry
   always_comb begin
      pix_chan[0] = pix.red;
      pix_chan[1] = pix.green;
      pix_chan[2] = pix.blue;
      pal_chan    = '0;
      diff        = '0;
      for (int k = 0; k < TREE_LEAVES; k++) begin
         for (int c = 0; c < 3; c++) begin
            if (k < PAL_ENTRIES) begin
               pal_chan = PALETTE_RGB[k][(2 - c) * CHAN_W +: CHAN_W];
               diff = (pix_chan[c] >= pal_chan) ? pix_chan[c] - pal_chan
                                                : pal_chan - pix_chan[c];
               sq_in[k][c] = SQ_W'(diff) * SQ_W'(diff);
            end else begin
               sq_in[k][c] = '0;
            end
         end
      end
   end

   // leaves hold distances, internal nodes hold the smaller child;
   // on a tie the left (lower index) child stays
   always_comb begin
      for (int k = 0; k < TREE_LEAVES; k++) begin
         if (k < PAL_ENTRIES) begin
            node_dist_in[k] = DIST_W'(sq_ff[k][0]) + DIST_W'(sq_ff[k][1])
                            + DIST_W'(sq_ff[k][2]);
         end else begin
            node_dist_in[k] = '1;
         end
         node_idx_in[k] = LEAF_IDX_W'(k);
      end
      for (int n = TREE_LEAVES; n < TREE_NODES; n++) begin
         if (node_dist_ff[2 * (n - TREE_LEAVES) + 1] < node_dist_ff[2 * (n - TREE_LEAVES)]) begin
            node_dist_in[n] = node_dist_ff[2 * (n - TREE_LEAVES) + 1];
            node_idx_in[n]  = node_idx_ff[2 * (n - TREE_LEAVES) + 1];
         end else begin
            node_dist_in[n] = node_dist_ff[2 * (n - TREE_LEAVES)];
            node_idx_in[n]  = node_idx_ff[2 * (n - TREE_LEAVES)];
         end
      end
   end

   assign valid_in = {valid_ff[PIPE_STAGES-2:0], issue};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff        <= sq_in;
      node_dist_ff <= node_dist_in;
      node_idx_ff  <= node_idx_in;
      side_ff[0]   <= pix.coord;
      for (int s = 1; s < PIPE_STAGES; s++) begin
         side_ff[s] <= side_ff[s-1];
      end
   end

   assign res_valid       = valid_ff[PIPE_STAGES-1];
   assign res.board_x     = side_ff[PIPE_STAGES-1].board_x;
   assign res.board_y     = side_ff[PIPE_STAGES-1].board_y;
   assign res.image_done  = side_ff[PIPE_STAGES-1].image_done;
   assign res.color_index = COLOR_W'(node_idx_ff[TREE_NODES-1]);

endmodule

`default_nettype wire

// ===== rtl/core/npq_out_queue.sv =====
// Result queue with a credit count that covers items still in the
// search pipeline. Depends on npq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module npq_out_queue
   import npq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         issue,
   input  logic         wr_valid,
   input  rsp_item_type wr_item,
   input  logic         pop,
   output logic         empty,
   output rsp_item_type head,
   output logic         credit_avail
);

   rsp_item_type          outq_ff [OUTQ_DEPTH];
   logic [OUTQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [OUTQ_PTR_W:0]   count_ff, count_in;
   logic [OUTQ_PTR_W:0]   credit_ff, credit_in;
   logic                  pop_xfer;

   assign empty        = (count_ff == '0);
   assign head         = outq_ff[rd_ptr_ff];
   assign pop_xfer     = pop && !empty;
   assign credit_avail = (credit_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + OUTQ_PTR_W'(wr_valid);
      rd_ptr_in = rd_ptr_ff + OUTQ_PTR_W'(pop_xfer);
      count_in  = count_ff + (OUTQ_PTR_W + 1)'(wr_valid) - (OUTQ_PTR_W + 1)'(pop_xfer);
      credit_in = credit_ff - (OUTQ_PTR_W + 1)'(issue) + (OUTQ_PTR_W + 1)'(pop_xfer);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         credit_ff <= (OUTQ_PTR_W + 1)'(OUTQ_DEPTH);
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         credit_ff <= credit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_valid) begin
         outq_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/nearest_palette_pixel_quantizer_unit.sv =====
// Top level of the nearest palette pixel quantizer.
// Depends on npq_pkg, npq_csr, npq_front, npq_search, npq_out_queue.
//
//   channel   | handshake               | payload
//   ----------+-------------------------+-----------------------------------------
//   pixel in  | push / full             | req_red, req_green, req_blue
//   result    | pop / empty             | rsp_board_x, rsp_board_y,
//             |                         | rsp_color_index, rsp_image_done
//   registers | psel/penable/pwrite/... | paddr, pwdata, prdata (pready tied high)
//
// Sustained rate is one pixel per clock while the result queue has credit.
// A pushed pixel passes the intake queue, the two squared-distance and sum
// stages, five minimum-tree stages and the result queue, then the result ports.
// Reset (synchronous) restores the register defaults, clears the counters
// and both queues; there is no clearing pass.
// The search pipeline never stalls: it only takes an item when the 16-entry
// result queue has a credit, so a stalled consumer backs up into the
// 4-entry intake queue and then raises full.
`timescale 1ns / 1ps
`default_nettype none

module nearest_palette_pixel_quantizer_unit
   import npq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // pixel intake
   input  logic                  push,
   output logic                  full,
   input  logic [CHAN_W-1:0]     req_red,
   input  logic [CHAN_W-1:0]     req_green,
   input  logic [CHAN_W-1:0]     req_blue,
   // results
   output logic                  empty,
   input  logic                  pop,
   output logic [BOARD_W-1:0]    rsp_board_x,
   output logic [BOARD_W-1:0]    rsp_board_y,
   output logic [COLOR_W-1:0]    rsp_color_index,
   output logic                  rsp_image_done,
   // configuration
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type      cfg;
   logic         size_wr;
   logic         item_valid;
   pix_item_type item;
   logic         credit_avail;
   logic         issue;
   logic         res_valid;
   rsp_item_type res;
   rsp_item_type head;

   // register file; a size write also restarts the position counters
   npq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg),
      .size_wr (size_wr)
   );

   // front: counters assign board coordinates at intake time, so the
   // back end only carries them alongside the search
   npq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .size_wr    (size_wr),
      .push       (push),
      .full       (full),
      .red        (req_red),
      .green      (req_green),
      .blue       (req_blue),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (issue)
   );

   // one transfer into the search pipeline per cycle while a result slot is reserved
   assign issue = item_valid && credit_avail;

   npq_search u_search (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .pix       (item),
      .res_valid (res_valid),
      .res       (res)
   );

   npq_out_queue u_out_queue (
      .clock        (clock),
      .reset        (reset),
      .issue        (issue),
      .wr_valid     (res_valid),
      .wr_item      (res),
      .pop          (pop),
      .empty        (empty),
      .head         (head),
      .credit_avail (credit_avail)
   );

   assign rsp_board_x     = head.board_x;
   assign rsp_board_y     = head.board_y;
   assign rsp_color_index = head.color_index;
   assign rsp_image_done  = head.image_done;

endmodule

`default_nettype wire

// ===== rtl/core/npq_checker.sv =====
// Port-level checks for the palette quantizer, bound to the top level.
// Depends on npq_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "nearest_palette_pixel_quantizer_unit_macros.svh"

module npq_checker
   import npq_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  full,
   input logic                  empty,
   input logic                  pop,
   input logic [BOARD_W-1:0]    rsp_board_x,
   input logic [BOARD_W-1:0]    rsp_board_y,
   input logic [COLOR_W-1:0]    rsp_color_index,
   input logic                  rsp_image_done,
   input logic                  psel,
   input logic                  penable,
   input logic                  pwrite,
   input logic [CSR_ADDR_W-1:0] paddr,
   input logic [CSR_DATA_W-1:0] pwdata,
   input logic [CSR_DATA_W-1:0] prdata,
   input logic                  pready
);

   // reset drains both queues
   `NPQ_ASSERT(a_reset_drains, reset |=> (empty && !full), "queues not drained by reset")

   // an x offset written is read back on the next cycle
   `NPQ_ASSERT_LIVE(a_offx_readback, (psel && penable && pwrite && pready && paddr[CSR_ADDR_W-1:2] == REG_OFFSET_X) |=> (paddr[CSR_ADDR_W-1:2] != REG_OFFSET_X || prdata == CSR_DATA_W'($past(pwdata[OFFSET_W-1:0]))), "offset x readback mismatch")

   // a waiting result stays until its transfer
   `NPQ_ASSERT_LIVE(a_rsp_held, (!empty && !pop) |=> !empty, "result dropped before transfer")

   `NPQ_ASSERT_LIVE(a_rsp_stable, (!empty && !pop) |=> ($stable(rsp_board_x) && $stable(rsp_board_y) && $stable(rsp_color_index) && $stable(rsp_image_done)), "stalled result changed")

endmodule

bind nearest_palette_pixel_quantizer_unit npq_checker u_npq_checker (.*);

`default_nettype wire
